FILE: design/bssl_pkg.sv
package bssl_pkg;

    // field widths
    localparam int DATA_W      = 16;
    localparam int ROW_W       = 2;
    localparam int THR_W       = 15;
    localparam int SCALE_W     = 32;
    localparam int ID_W        = 16;
    localparam int ACT_W       = 17;
    localparam int REGION_W    = 2;
    localparam int LANE_FIELDS = 4;
    localparam int OFF_W       = 16;
    localparam int FRAC_W      = 16;
    localparam int PROD_W      = OFF_W + SCALE_W;

    // stream and register port widths
    localparam int S_TDATA_W  = 2 * LANE_FIELDS * DATA_W;
    localparam int M_TDATA_W  = ((ID_W + ACT_W + 7) / 8) * 8;
    localparam int TUSER_W    = 2;
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    // parameter defaults
    localparam int ROWS_DEFAULT      = 4;
    localparam int LANES_DEFAULT     = 4;
    localparam int ROM_DEPTH_DEFAULT = 4096;

    // register map
    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INDEX_SCALE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ID_BASE     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BIAS0       = 3'd3;

    // register reset values
    localparam logic [THR_W-1:0]   THRESHOLD_RST = 15'd2048;
    localparam logic [SCALE_W-1:0] SCALE_RST     = 32'd65504;
    localparam logic [ID_W-1:0]    ID_BASE_RST   = 16'd0;

    // result codes
    localparam logic [REGION_W-1:0] REGION_LOW   = 2'd0;
    localparam logic [REGION_W-1:0] REGION_HIGH  = 2'd1;
    localparam logic [REGION_W-1:0] REGION_TABLE = 2'd2;

    localparam logic [ACT_W-1:0] ACT_ONE  = 17'h10000;
    localparam logic [ACT_W-1:0] ACT_ZERO = 17'h00000;

    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic [ID_W-1:0]     result_id;
    } tag_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage

FILE: design/bias_sum_sigmoid_lut.sv
// from an input transfer to its result on the m_axis side, the stages are sum,
// compare, index multiply and rom read, each a register stage whose enable backs up
// only into full stages; throughput is one item per cycle while m_axis_tready is high or a stage is empty
// reset: aresetn synchronous active low, empties the pipe and restores the
// threshold, scale, identifier base and row biases to their defaults
// the sigmoid rom is constant and needs no fill after reset
module bias_sum_sigmoid_lut #(
    parameter int ROWS      = bssl_pkg::ROWS_DEFAULT,
    parameter int LANES     = bssl_pkg::LANES_DEFAULT,
    parameter int ROM_DEPTH = bssl_pkg::ROM_DEPTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    // apb configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bssl_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bssl_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bssl_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready,

    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // xpart_0, xpart_1, xpart_2, xpart_3, hpart_0, hpart_1, hpart_2, hpart_3
    input  logic [bssl_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // row
    input  logic [bssl_pkg::TUSER_W-1:0]       s_axis_tuser,

    // result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // result_id, activation, zero pad
    output logic [bssl_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // region
    output logic [bssl_pkg::TUSER_W-1:0]       m_axis_tuser
);

    localparam int NSUM  = (LANES < bssl_pkg::LANE_FIELDS) ? LANES : bssl_pkg::LANE_FIELDS;
    // bias plus two products per lane, with room for the carries
    localparam int SUM_W = bssl_pkg::DATA_W + $clog2(2 * NSUM + 1);
    localparam int IDX_W = $clog2(ROM_DEPTH);
    localparam int PAD_W = bssl_pkg::M_TDATA_W - bssl_pkg::ID_W - bssl_pkg::ACT_W;

    // configuration
    logic [bssl_pkg::THR_W-1:0]   threshold;
    logic [bssl_pkg::SCALE_W-1:0] index_scale;
    logic [bssl_pkg::ID_W-1:0]    id_base;
    logic [bssl_pkg::DATA_W-1:0]  bias [ROWS];

    // pipeline occupancy, one flag per stage
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    bssl_pkg::stage_en_t en;

    // datapath between stages
    logic signed [SUM_W-1:0]          sum;
    logic [bssl_pkg::ROW_W-1:0]       row1;
    bssl_pkg::tag_t                   tag3;
    bssl_pkg::tag_t                   tag4;
    logic [IDX_W-1:0]                 idx3;
    logic [bssl_pkg::ACT_W-1:0]       rom_q;
    logic [bssl_pkg::ACT_W-1:0]       activation;

    logic in_xfer;
    logic out_xfer;

    assign pready = 1'b1;

    bssl_regs #(
        .ROWS (ROWS)
    ) u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .threshold   (threshold),
        .index_scale (index_scale),
        .id_base     (id_base),
        .bias        (bias)
    );

    // a stage takes a new item when it is empty or its content moves on
    always_comb begin
        en.s4 = !v4_reg || m_axis_tready;
        en.s3 = !v3_reg || en.s4;
        en.s2 = !v2_reg || en.s3;
        en.s1 = !v1_reg || en.s2;
    end

    assign s_axis_tready = en.s1;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = m_axis_tvalid && m_axis_tready;

    always_comb begin
        v1_next = en.s1 ? s_axis_tvalid : v1_reg;
        v2_next = en.s2 ? v1_reg        : v2_reg;
        v3_next = en.s3 ? v2_reg        : v3_reg;
        v4_next = en.s4 ? v3_reg        : v4_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // stage 1: bias plus partial products
    bssl_sum #(
        .ROWS  (ROWS),
        .LANES (LANES),
        .SUM_W (SUM_W)
    ) u_sum (
        .aclk    (aclk),
        .en      (en.s1),
        .row     (s_axis_tuser[bssl_pkg::ROW_W-1:0]),
        .lanes   (s_axis_tdata),
        .bias    (bias),
        .sum     (sum),
        .row_out (row1)
    );

    // stages 2 and 3: saturation compare, then table index
    bssl_index #(
        .SUM_W     (SUM_W),
        .ROM_DEPTH (ROM_DEPTH)
    ) u_index (
        .aclk        (aclk),
        .en          (en),
        .sum         (sum),
        .row         (row1),
        .threshold   (threshold),
        .index_scale (index_scale),
        .id_base     (id_base),
        .tag         (tag3),
        .idx         (idx3)
    );

    // stage 4: rom read into the result register
    bssl_lut #(
        .ROM_DEPTH (ROM_DEPTH)
    ) u_lut (
        .aclk    (aclk),
        .en      (en.s4),
        .idx     (idx3),
        .tag_in  (tag3),
        .tag_out (tag4),
        .rom_q   (rom_q)
    );

    // saturated items ignore the rom word
    always_comb begin
        case (tag4.region)
            bssl_pkg::REGION_TABLE: activation = rom_q;
            bssl_pkg::REGION_HIGH:  activation = bssl_pkg::ACT_ONE;
            default:                activation = bssl_pkg::ACT_ZERO;
        endcase
    end

    assign m_axis_tvalid = v4_reg;
    assign m_axis_tdata  = {PAD_W'(0), activation, tag4.result_id};
    assign m_axis_tuser  = tag4.region;

    // input stalls only when every stage holds an item and the sink holds off
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg && !m_axis_tready))
        else $error("input stalled with room in the pipe");

    // items in flight change only by transfers
    a_conserve: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            ($countones({v1_reg, v2_reg, v3_reg, v4_reg}) ==
             $countones($past({v1_reg, v2_reg, v3_reg, v4_reg}))
             + int'($past(in_xfer)) - int'($past(out_xfer))))
        else $error("item lost or duplicated in the pipe");

    // activation never exceeds 1.0
    a_act_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (activation <= bssl_pkg::ACT_ONE))
        else $error("activation above 1.0");

endmodule

FILE: design/bssl_regs.sv
module bssl_regs #(
    parameter int ROWS = bssl_pkg::ROWS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bssl_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bssl_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bssl_pkg::APB_DATA_W-1:0]    prdata,
    output logic [bssl_pkg::THR_W-1:0]         threshold,
    output logic [bssl_pkg::SCALE_W-1:0]       index_scale,
    output logic [bssl_pkg::ID_W-1:0]          id_base,
    output logic [bssl_pkg::DATA_W-1:0]        bias [ROWS]
);

    logic [bssl_pkg::THR_W-1:0]     threshold_reg;
    logic [bssl_pkg::SCALE_W-1:0]   index_scale_reg;
    logic [bssl_pkg::ID_W-1:0]      id_base_reg;
    logic [bssl_pkg::DATA_W-1:0]    bias_reg [ROWS];
    logic [bssl_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[bssl_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg   <= bssl_pkg::THRESHOLD_RST;
            index_scale_reg <= bssl_pkg::SCALE_RST;
            id_base_reg     <= bssl_pkg::ID_BASE_RST;
            for (int k = 0; k < ROWS; k++) begin
                bias_reg[k] <= '0;
            end
        end else if (wr_en) begin
            case (reg_idx)
                bssl_pkg::REG_THRESHOLD: begin
                    threshold_reg <= pwdata[bssl_pkg::THR_W-1:0];
                end
                bssl_pkg::REG_INDEX_SCALE: begin
                    index_scale_reg <= pwdata[bssl_pkg::SCALE_W-1:0];
                end
                bssl_pkg::REG_ID_BASE: begin
                    id_base_reg <= pwdata[bssl_pkg::ID_W-1:0];
                end
                default: begin
                end
            endcase
            for (int k = 0; k < ROWS; k++) begin
                if (reg_idx == bssl_pkg::REG_IDX_W'(bssl_pkg::REG_BIAS0 + k)) begin
                    bias_reg[k] <= pwdata[bssl_pkg::DATA_W-1:0];
                end
            end
        end
    end

    // read back
    always_comb begin
        case (reg_idx)
            bssl_pkg::REG_THRESHOLD:   prdata = bssl_pkg::APB_DATA_W'(threshold_reg);
            bssl_pkg::REG_INDEX_SCALE: prdata = bssl_pkg::APB_DATA_W'(index_scale_reg);
            bssl_pkg::REG_ID_BASE:     prdata = bssl_pkg::APB_DATA_W'(id_base_reg);
            default:                   prdata = '0;
        endcase
        for (int k = 0; k < ROWS; k++) begin
            if (reg_idx == bssl_pkg::REG_IDX_W'(bssl_pkg::REG_BIAS0 + k)) begin
                prdata = bssl_pkg::APB_DATA_W'(bias_reg[k]);
            end
        end
    end

    assign threshold   = threshold_reg;
    assign index_scale = index_scale_reg;
    assign id_base     = id_base_reg;
    assign bias        = bias_reg;

endmodule

FILE: design/bssl_sum.sv
module bssl_sum #(
    parameter int ROWS  = bssl_pkg::ROWS_DEFAULT,
    parameter int LANES = bssl_pkg::LANES_DEFAULT,
    parameter int SUM_W = 20
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [bssl_pkg::ROW_W-1:0]        row,
    input  logic [bssl_pkg::S_TDATA_W-1:0]    lanes,
    input  logic [bssl_pkg::DATA_W-1:0]       bias [ROWS],
    output logic signed [SUM_W-1:0]           sum,
    output logic [bssl_pkg::ROW_W-1:0]        row_out
);

    localparam int NSUM = (LANES < bssl_pkg::LANE_FIELDS) ? LANES : bssl_pkg::LANE_FIELDS;
    localparam int H_OFS = bssl_pkg::LANE_FIELDS * bssl_pkg::DATA_W;

    logic [bssl_pkg::DATA_W-1:0]       bias_sel;
    logic signed [SUM_W-1:0]           acc;
    logic signed [SUM_W-1:0]           sum_reg;
    logic [bssl_pkg::ROW_W-1:0]        row_reg;

    // rows past the bias bank take a zero bias
    always_comb begin
        bias_sel = '0;
        for (int k = 0; k < ROWS; k++) begin
            if (row == bssl_pkg::ROW_W'(k)) begin
                bias_sel = bias[k];
            end
        end
    end

    always_comb begin
        acc = SUM_W'(signed'(bias_sel));
        for (int l = 0; l < NSUM; l++) begin
            acc = acc
                + SUM_W'(signed'(lanes[bssl_pkg::DATA_W*l +: bssl_pkg::DATA_W]))
                + SUM_W'(signed'(lanes[H_OFS + bssl_pkg::DATA_W*l +: bssl_pkg::DATA_W]));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg <= acc;
            row_reg <= row;
        end
    end

    assign sum     = sum_reg;
    assign row_out = row_reg;

endmodule

FILE: design/bssl_index.sv
module bssl_index #(
    parameter int SUM_W     = 20,
    parameter int ROM_DEPTH = bssl_pkg::ROM_DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  bssl_pkg::stage_en_t               en,
    input  logic signed [SUM_W-1:0]           sum,
    input  logic [bssl_pkg::ROW_W-1:0]        row,
    input  logic [bssl_pkg::THR_W-1:0]        threshold,
    input  logic [bssl_pkg::SCALE_W-1:0]      index_scale,
    input  logic [bssl_pkg::ID_W-1:0]         id_base,
    output bssl_pkg::tag_t                    tag,
    output logic [$clog2(ROM_DEPTH)-1:0]      idx
);

    localparam int IDX_W = $clog2(ROM_DEPTH);
    localparam logic [bssl_pkg::SCALE_W-1:0] IDX_MAX = bssl_pkg::SCALE_W'(ROM_DEPTH - 1);

    logic signed [SUM_W-1:0]               thr_s;
    logic signed [SUM_W-1:0]               off_full;
    logic [bssl_pkg::REGION_W-1:0]         region;
    bssl_pkg::tag_t                        tag2_reg;
    bssl_pkg::tag_t                        tag3_reg;
    logic [bssl_pkg::OFF_W-1:0]            off_reg;
    logic [bssl_pkg::PROD_W-1:0]           prod;
    logic [bssl_pkg::SCALE_W-1:0]          idx_full;
    logic [IDX_W-1:0]                      idx_sat;
    logic [IDX_W-1:0]                      idx_reg;

    // saturation compare; low side wins when the threshold is zero
    assign thr_s    = signed'(SUM_W'(threshold));
    assign off_full = sum + thr_s;

    always_comb begin
        if (sum <= -thr_s) begin
            region = bssl_pkg::REGION_LOW;
        end else if (sum >= thr_s) begin
            region = bssl_pkg::REGION_HIGH;
        end else begin
            region = bssl_pkg::REGION_TABLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            tag2_reg.region    <= region;
            tag2_reg.result_id <= id_base + bssl_pkg::ID_W'(row);
            off_reg            <= off_full[bssl_pkg::OFF_W-1:0];
        end
    end

    // offset times Q16.16 scale, integer part clipped to the top entry
    assign prod     = bssl_pkg::PROD_W'(off_reg) * bssl_pkg::PROD_W'(index_scale);
    assign idx_full = prod[bssl_pkg::PROD_W-1:bssl_pkg::FRAC_W];
    assign idx_sat  = (idx_full > IDX_MAX) ? IDX_MAX[IDX_W-1:0] : idx_full[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            tag3_reg <= tag2_reg;
            idx_reg  <= idx_sat;
        end
    end

    assign tag = tag3_reg;
    assign idx = idx_reg;

endmodule

FILE: design/bssl_lut.sv
module bssl_lut #(
    parameter int ROM_DEPTH = bssl_pkg::ROM_DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [$clog2(ROM_DEPTH)-1:0]      idx,
    input  bssl_pkg::tag_t                    tag_in,
    output bssl_pkg::tag_t                    tag_out,
    output logic [bssl_pkg::ACT_W-1:0]        rom_q
);

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    // shift-subtract quotient, evaluated only while building the table
    function automatic logic [63:0] long_div(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int j = 63; j >= 0; j--) begin
            r = {r[62:0], a[j]};
            if (r >= b) begin
                r    = r - b;
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // round(65536 * sigmoid(x)) over x in [-8, 8], exp in Q30
    function automatic logic [bssl_pkg::ACT_W-1:0] sig_entry(input int unsigned i);
        logic [63:0] den;
        logic [63:0] twice;
        logic [63:0] num;
        logic [63:0] z;
        logic [63:0] t;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] n;
        logic [63:0] v;
        logic        neg;
        den   = 64'(ROM_DEPTH - 1);
        twice = 64'(i) << 1;
        neg   = twice < den;
        num   = neg ? den - twice : twice - den;
        z     = long_div((64'd2048 * num) << 14, den);
        t     = Q30_ONE;
        e     = Q30_ONE;
        for (int k = 1; k <= 5; k++) begin
            t = long_div((t * z) >> 30, 64'(k));
            if (k[0]) begin
                e = e - t;
            end else begin
                e = e + t;
            end
        end
        for (int k = 0; k < 8; k++) begin
            e = (e * e + (Q30_ONE >> 1)) >> 30;
        end
        d = Q30_ONE + e;
        n = neg ? (e << 16) : (64'd65536 << 30);
        v = long_div(n + (d >> 1), d);
        if (v > 64'd65536) begin
            v = 64'd65536;
        end
        return v[bssl_pkg::ACT_W-1:0];
    endfunction

    logic [bssl_pkg::ACT_W-1:0] rom_w [ROM_DEPTH];
    logic [bssl_pkg::ACT_W-1:0] rom_q_reg;
    bssl_pkg::tag_t             tag_reg;

    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
        localparam logic [bssl_pkg::ACT_W-1:0] ENTRY = sig_entry(g);
        assign rom_w[g] = ENTRY;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rom_q_reg <= rom_w[idx];
            tag_reg   <= tag_in;
        end
    end

    assign rom_q   = rom_q_reg;
    assign tag_out = tag_reg;

endmodule
